>>> src/lea_pkg.sv
// ----------------------------------------------------------------------------
// lea_pkg: life expectancy accumulator types and constants
// Request and result payloads, status codes, sequencer states and the
// fixed-point coefficients of the separation factors.
// ----------------------------------------------------------------------------
`default_nettype none
package lea_pkg;

    localparam int RATE_WIDTH = 32;

    typedef struct packed {
        logic signed [RATE_WIDTH-1:0] rate;
        logic                         rate_missing;
        logic                         rate_infinite;
        logic                         open_group;
    } item_t;

    typedef struct packed {
        logic [31:0] life_expectancy;
        logic [1:0]  row_status;
        logic        probability_clipped;
    } result_t;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_MISSING,
        STAT_NEGATIVE,
        STAT_SATURATED
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FACTOR_MUL,
        S_FACTOR_DIV,
        S_AM_MUL,
        S_DEN_MUL,
        S_SURV_MUL,
        S_SURV_DIV,
        S_YEARS_MUL,
        S_OPEN_DIV,
        S_EMIT
    } state_t;

    localparam logic CFG_AGE_LAYOUT = 1'b0;
    localparam logic CFG_A0_METHOD  = 1'b1;

    localparam logic [1:0] METHOD_MID       = 2'd0;
    localparam logic [1:0] METHOD_CD_FEMALE = 2'd1;
    localparam logic [1:0] METHOD_CD_MALE   = 2'd2;

    localparam logic [31:0] ONE_Q30   = 32'd1 << 30;
    localparam logic [63:0] ONE_Q56   = 64'd1 << 56;
    localparam logic [31:0] YEARS_MAX = 32'hFFFF_FFFF;
    localparam logic [31:0] CLIP_RATE = 32'd107374183;
    localparam logic [31:0] A_FIVE    = 32'd5 << 27;
    localparam logic [31:0] A_MID0    = 32'd1 << 27;
    localparam logic [31:0] A_MID1    = 32'd2 << 28;
    localparam logic [31:0] KNEE      = 32'(((64'd107 << 28) + 64'd999) / 64'd1000);
    localparam logic [31:0] DIV_1000  = 32'd1000;

    localparam logic [31:0] A_F0_HIGH = 32'((64'd350 << 28) / 64'd1000);
    localparam logic [31:0] A_F1_HIGH = 32'((64'd1361 << 28) / 64'd1000);
    localparam logic [31:0] A_M0_HIGH = 32'((64'd330 << 28) / 64'd1000);
    localparam logic [31:0] A_M1_HIGH = 32'((64'd1352 << 28) / 64'd1000);

    localparam logic [39:0] CD_F0_BASE = 40'd53 << 28;
    localparam logic [39:0] CD_F1_BASE = 40'd1522 << 28;
    localparam logic [39:0] CD_M0_BASE = 40'd45 << 28;
    localparam logic [39:0] CD_M1_BASE = 40'd1651 << 28;

    typedef struct packed {
        logic [39:0] base;
        logic [11:0] slope;
        logic        sub;
        logic [31:0] a_high;
    } cd_coef_t;

    function automatic cd_coef_t cd_coef(input logic [1:0] method, input logic upper);
        cd_coef_t c;
        c = '{base: CD_F0_BASE, slope: 12'd2800, sub: 1'b0, a_high: A_F0_HIGH};
        if (method == METHOD_CD_MALE)
        begin
            if (upper)
                c = '{base: CD_M1_BASE, slope: 12'd2816, sub: 1'b1, a_high: A_M1_HIGH};
            else
                c = '{base: CD_M0_BASE, slope: 12'd2684, sub: 1'b0, a_high: A_M0_HIGH};
        end
        else if (upper)
        begin
            c = '{base: CD_F1_BASE, slope: 12'd1518, sub: 1'b1, a_high: A_F1_HIGH};
        end
        return c;
    endfunction

    function automatic logic [32:0] years_add(input logic [31:0] a, input logic [31:0] b);
        return {1'b0, a} + {1'b0, b};
    endfunction

endpackage
`default_nettype wire

>>> src/life_expectancy_ax_accumulator.sv
// ----------------------------------------------------------------------------
// life_expectancy_ax_accumulator: abridged life table life expectancy
// Accumulates survivors and person-years over age-group rates and emits
// life expectancy, status and clip flag at the open group.
// ----------------------------------------------------------------------------
//  channel  | signals                              | role
//  item     | item_valid, item_ready, item         | one age-group rate request
//  result   | result_valid, result_ready, result   | one result per open group
//  cfg      | cfg_write, cfg_index, cfg_data       | register writes, no wait
//
//  One bit-serial unit (add-shift multiply, restoring divide) runs every pass.
//  Closed group: 5 passes; a*m reaching one skips survivor mul/div; CD low adds
//  factor mul/div. Open group: divide. Stopped, clipped, flagged items skip the unit.
//  A request is taken only in idle; a held result stalls only the open group emit.
//  Reset: asynchronous, clears row state and the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none
module life_expectancy_ax_accumulator
    import lea_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_ready,
    input  wire item_t   item,
    output logic         result_valid,
    input  wire logic    result_ready,
    output result_t      result,
    input  wire logic    cfg_write,
    input  wire logic    cfg_index,
    input  wire logic [1:0] cfg_data
);

    state_t      state_reg, state_next, launch;
    logic [63:0] acc_reg, acc_next, opa_reg, opa_next;
    logic [31:0] opb_reg, opb_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] s_reg, s_next, years_reg, years_next, first_reg, first_next;
    logic [1:0]  grp_reg, grp_next;
    logic        stop_reg, stop_next, clip_reg, clip_next;
    status_t     status_reg, status_next;
    logic        layout_reg, layout_next;
    logic [1:0]  method_reg, method_next;
    logic [31:0] m_reg, m_next, a_reg, a_next, sn_reg, sn_next;
    logic [2:0]  n_reg, n_next;
    logic [28:0] num_reg, num_next;
    logic [35:0] den_reg, den_next;
    logic        g1_reg, g1_next;
    logic        res_valid_reg, res_valid_next;
    result_t     res_reg, res_next;

    logic [RATE_WIDTH+15:0] rate_ext;
    logic [31:0] m, m0;
    logic        neg, inf, open_sat, clip_hit, cd_on, high, op_last, emit_fire;
    logic [1:0]  grp_eff;
    cd_coef_t    cd, cd_item;
    logic [63:0] prod, ysum;
    logic [36:0] div_t, div_d, div_r;
    logic        div_ge;
    logic [31:0] quo;
    logic [39:0] fnum;
    logic [33:0] s5;
    logic [32:0] nsn, ysat;

    // decode the request
    always_comb
    begin
        rate_ext = {item.rate, 16'b0};
        m        = rate_ext[RATE_WIDTH+15 -: 32];
        neg      = item.rate[RATE_WIDTH-1];
        inf      = item.rate_infinite;
        grp_eff  = layout_reg ? grp_reg : 2'd2;
        m0       = (grp_reg == 2'd0) ? m : first_reg;
        cd       = cd_coef(method_reg, grp_reg[0]);
        cd_on    = (method_reg == METHOD_CD_FEMALE) || (method_reg == METHOD_CD_MALE);
        high     = m0 >= KNEE;
        clip_hit = inf || (m >= CLIP_RATE);
        open_sat = {14'b0, s_reg[31:14]} >= m;
        if (stop_reg || item.rate_missing || (!inf && neg))
            launch = item.open_group ? S_EMIT : S_IDLE;
        else if (item.open_group)
            launch = (inf || open_sat) ? S_EMIT : S_OPEN_DIV;
        else if (grp_eff == 2'd2)
            launch = clip_hit ? S_IDLE : S_AM_MUL;
        else if (inf)
            launch = S_IDLE;
        else if (cd_on && !high)
            launch = S_FACTOR_MUL;
        else
            launch = S_AM_MUL;
    end

    // serial unit
    always_comb
    begin
        prod   = acc_reg + (opb_reg[0] ? opa_reg : 64'd0);
        div_t  = {acc_reg[35:0], opb_reg[31]};
        div_d  = {1'b0, opa_reg[35:0]};
        div_ge = div_t >= div_d;
        div_r  = div_ge ? div_t - div_d : div_t;
        quo    = {opb_reg[30:0], div_ge};
        cd_item = cd_coef(method_reg, g1_reg);
        fnum   = cd_item.sub ? cd_item.base - prod[39:0] : cd_item.base + prod[39:0];
        s5     = {s_reg, 2'b00} + {2'b00, s_reg};
        nsn    = (n_reg[0] ? {1'b0, sn_reg} : 33'd0) + (n_reg[2] ? {sn_reg[30:0], 2'b00} : 33'd0);
        ysum   = {3'b0, nsn, 28'b0} + prod;
    end

    // sequencer outputs
    always_comb
    begin
        item_ready = (state_reg == S_IDLE);
        op_last    = (cnt_reg == 5'd31);
        emit_fire  = (state_reg == S_EMIT) && (!res_valid_reg || result_ready);
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:       if (item_valid) state_next = launch;
            S_FACTOR_MUL: if (op_last) state_next = S_FACTOR_DIV;
            S_FACTOR_DIV: if (op_last) state_next = S_AM_MUL;
            S_AM_MUL:     if (op_last) state_next = S_DEN_MUL;
            S_DEN_MUL:    if (op_last) state_next = (num_reg == 29'd0) ? S_YEARS_MUL : S_SURV_MUL;
            S_SURV_MUL:   if (op_last) state_next = S_SURV_DIV;
            S_SURV_DIV:   if (op_last) state_next = S_YEARS_MUL;
            S_YEARS_MUL:  if (op_last) state_next = S_IDLE;
            S_OPEN_DIV:   if (op_last) state_next = S_EMIT;
            S_EMIT:       if (emit_fire) state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        acc_next = acc_reg; opa_next = opa_reg; opb_next = opb_reg;
        cnt_next = (state_reg == S_IDLE || state_reg == S_EMIT) ? 5'd0 : cnt_reg + 5'd1;
        s_next = s_reg; years_next = years_reg; first_next = first_reg; grp_next = grp_reg;
        stop_next = stop_reg; clip_next = clip_reg; status_next = status_reg;
        layout_next = layout_reg; method_next = method_reg;
        m_next = m_reg; a_next = a_reg; sn_next = sn_reg; n_next = n_reg;
        num_next = num_reg; den_next = den_reg; g1_next = g1_reg;
        res_next = res_reg;
        res_valid_next = res_valid_reg && !result_ready;
        ysat = 33'd0;

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_AGE_LAYOUT: layout_next = cfg_data[0];
                CFG_A0_METHOD:  method_next = cfg_data;
                default:        method_next = method_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid && !stop_reg)
                begin
                    m_next   = m;
                    acc_next = 64'd0;
                    if (item.rate_missing)
                    begin
                        if (status_reg == STAT_OK) status_next = STAT_MISSING;
                        stop_next = 1'b1;
                    end
                    else if (!inf && neg)
                    begin
                        if (status_reg == STAT_OK) status_next = STAT_NEGATIVE;
                        stop_next = 1'b1;
                    end
                    else if (item.open_group)
                    begin
                        if (inf || open_sat)
                        begin
                            if (!inf) years_next = YEARS_MAX;
                            if (status_reg == STAT_OK) status_next = STAT_SATURATED;
                        end
                        else
                        begin
                            acc_next = {46'b0, s_reg[31:14]};
                            opb_next = {s_reg[13:0], 18'b0};
                            opa_next = {32'b0, m};
                        end
                    end
                    else
                    begin
                        if (grp_reg == 2'd0) first_next = inf ? 32'd0 : m;
                        if (grp_reg != 2'd2) grp_next = grp_reg + 2'd1;
                        g1_next  = grp_reg[0];
                        n_next   = (grp_eff == 2'd2) ? 3'd5 : (grp_reg[0] ? 3'd4 : 3'd1);
                        opb_next = m;
                        if (grp_eff == 2'd2)
                        begin
                            a_next   = A_FIVE;
                            opa_next = {32'b0, A_FIVE};
                            if (clip_hit)
                            begin
                                ysat = years_add(years_reg, {9'b0, s5[33:11]});
                                years_next = ysat[32] ? YEARS_MAX : ysat[31:0];
                                if ((ysat[32] || inf) && status_reg == STAT_OK)
                                    status_next = STAT_SATURATED;
                                s_next    = 32'd0;
                                clip_next = 1'b1;
                                stop_next = 1'b1;
                            end
                        end
                        else if (inf)
                        begin
                            if (status_reg == STAT_OK) status_next = STAT_SATURATED;
                            stop_next = 1'b1;
                        end
                        else if (cd_on && !high)
                        begin
                            opa_next = {32'b0, m0};
                            opb_next = {20'b0, cd.slope};
                        end
                        else
                        begin
                            a_next   = cd_on ? cd.a_high : (grp_reg[0] ? A_MID1 : A_MID0);
                            opa_next = {32'b0, a_next};
                        end
                    end
                end
            end
            S_FACTOR_MUL, S_AM_MUL, S_DEN_MUL, S_SURV_MUL, S_YEARS_MUL:
            begin
                acc_next = prod;
                opa_next = {opa_reg[62:0], 1'b0};
                opb_next = {1'b0, opb_reg[31:1]};
                if (op_last)
                begin
                    acc_next = 64'd0;
                    case (state_reg)
                        S_FACTOR_MUL:
                        begin
                            acc_next = {56'b0, fnum[39:32]};
                            opb_next = fnum[31:0];
                            opa_next = {32'b0, DIV_1000};
                        end
                        S_AM_MUL:
                        begin
                            if (prod >= ONE_Q56)
                            begin
                                clip_next = 1'b1;
                                num_next  = 29'd0;
                            end
                            else
                            begin
                                num_next = 29'((ONE_Q56 - prod) >> 28);
                            end
                            opa_next = {32'b0, m_reg};
                            opb_next = {1'b0, n_reg, 28'b0} - a_reg;
                        end
                        S_DEN_MUL:
                        begin
                            den_next = 36'((ONE_Q56 + prod) >> 28);
                            if (num_reg == 29'd0)
                            begin
                                sn_next  = 32'd0;
                                opa_next = {32'b0, a_reg};
                                opb_next = s_reg;
                            end
                            else
                            begin
                                opa_next = {32'b0, s_reg};
                                opb_next = {3'b0, num_reg};
                            end
                        end
                        S_SURV_MUL:
                        begin
                            acc_next = {32'b0, prod[63:32]};
                            opb_next = prod[31:0];
                            opa_next = {28'b0, den_reg};
                        end
                        default:
                        begin
                            ysat = years_add(years_reg, {6'b0, ysum[63:38]});
                            years_next = ysat[32] ? YEARS_MAX : ysat[31:0];
                            if (ysat[32] && status_reg == STAT_OK) status_next = STAT_SATURATED;
                            s_next = sn_reg;
                        end
                    endcase
                end
            end
            S_FACTOR_DIV, S_SURV_DIV, S_OPEN_DIV:
            begin
                acc_next = {28'b0, div_r[35:0]};
                opb_next = quo;
                if (op_last)
                begin
                    acc_next = 64'd0;
                    case (state_reg)
                        S_FACTOR_DIV:
                        begin
                            a_next   = quo;
                            opa_next = {32'b0, quo};
                            opb_next = m_reg;
                        end
                        S_SURV_DIV:
                        begin
                            sn_next  = quo;
                            opa_next = {32'b0, a_reg};
                            opb_next = s_reg - quo;
                        end
                        default:
                        begin
                            ysat = years_add(years_reg, quo);
                            years_next = ysat[32] ? YEARS_MAX : ysat[31:0];
                            if (ysat[32] && status_reg == STAT_OK) status_next = STAT_SATURATED;
                        end
                    endcase
                end
            end
            S_EMIT:
            begin
                if (emit_fire)
                begin
                    res_valid_next = 1'b1;
                    res_next.life_expectancy =
                        (status_reg == STAT_MISSING || status_reg == STAT_NEGATIVE) ?
                        32'd0 : years_reg;
                    res_next.row_status = status_reg;
                    res_next.probability_clipped = clip_reg;
                    s_next = ONE_Q30; years_next = 32'd0; first_next = 32'd0;
                    grp_next = 2'd0; stop_next = 1'b0; status_next = STAT_OK;
                    clip_next = 1'b0;
                end
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= 5'd0;
            s_reg         <= ONE_Q30;
            years_reg     <= 32'd0;
            first_reg     <= 32'd0;
            grp_reg       <= 2'd0;
            stop_reg      <= 1'b0;
            clip_reg      <= 1'b0;
            status_reg    <= STAT_OK;
            layout_reg    <= 1'b1;
            method_reg    <= METHOD_MID;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            s_reg         <= s_next;
            years_reg     <= years_next;
            first_reg     <= first_next;
            grp_reg       <= grp_next;
            stop_reg      <= stop_next;
            clip_reg      <= clip_next;
            status_reg    <= status_next;
            layout_reg    <= layout_next;
            method_reg    <= method_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        opa_reg <= opa_next;
        opb_reg <= opb_next;
        m_reg   <= m_next;
        a_reg   <= a_next;
        sn_reg  <= sn_next;
        n_reg   <= n_next;
        num_reg <= num_next;
        den_reg <= den_next;
        g1_reg  <= g1_next;
        res_reg <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> cnt_reg == 5'd0)
        else $error("serial counter not parked in idle");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |=> (res_valid_reg && s_reg == ONE_Q30 && years_reg == 32'd0 &&
                       status_reg == STAT_OK))
        else $error("row state not cleared after emit");

    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && (res_reg.row_status == STAT_MISSING ||
                          res_reg.row_status == STAT_NEGATIVE)
        |-> res_reg.life_expectancy == 32'd0)
        else $error("flagged row carries years");

    a_surv_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_YEARS_MUL && op_last) |-> sn_reg <= s_reg)
        else $error("survivor fraction grew");

    a_grp_range: assert property (@(posedge clk) disable iff (!rst_n)
        grp_reg != 2'd3)
        else $error("group index past saturation");

endmodule
`default_nettype wire

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb: life expectancy accumulator testbench
// Drives age-group rate requests in rows under both layouts and all a0
// methods, predicts each open-group result in a scoreboard and compares
// every field. Random gaps on both sides and a phase of long result hold-offs.
// ----------------------------------------------------------------------------
`default_nettype none

class life_scoreboard;
    bit          layout_abridged;
    logic [1:0]  method;
    logic [63:0] surv;
    logic [63:0] years;
    logic [63:0] rate0;
    int unsigned grp_idx;
    bit          stopped;
    logic [1:0]  status;
    bit          clipped;
    lea_pkg::result_t pending[$];
    int unsigned errors;

    function new();
        layout_abridged = 1'b1;
        method = lea_pkg::METHOD_MID;
        errors = 0;
        clear_row();
    endfunction

    function void clear_row();
        surv = 64'd1 << 30;
        years = 0;
        rate0 = 0;
        grp_idx = 0;
        stopped = 0;
        status = lea_pkg::STAT_OK;
        clipped = 0;
    endfunction

    function void set_status(logic [1:0] code);
        if (status == lea_pkg::STAT_OK)
            status = code;
    endfunction

    function void add_years(logic [63:0] y);
        logic [63:0] sum;
        sum = years + y;
        if (y > 64'hFFFF_FFFF || sum > 64'hFFFF_FFFF)
        begin
            years = 64'hFFFF_FFFF;
            set_status(lea_pkg::STAT_SATURATED);
        end
        else
            years = sum;
    endfunction

    function logic [63:0] sep_factor(int unsigned g, logic [63:0] m0);
        bit upper;
        upper = m0 * 64'd1000 >= (64'd107 << 28);
        if (method == lea_pkg::METHOD_CD_FEMALE)
        begin
            if (g == 0)
                return upper ? (64'd350 << 28) / 1000 : ((64'd53 << 28) + 64'd2800 * m0) / 1000;
            return upper ? (64'd1361 << 28) / 1000 : ((64'd1522 << 28) - 64'd1518 * m0) / 1000;
        end
        if (method == lea_pkg::METHOD_CD_MALE)
        begin
            if (g == 0)
                return upper ? (64'd330 << 28) / 1000 : ((64'd45 << 28) + 64'd2684 * m0) / 1000;
            return upper ? (64'd1352 << 28) / 1000 : ((64'd1651 << 28) - 64'd2816 * m0) / 1000;
        end
        return g == 0 ? (64'd1 << 27) : (64'd2 << 28);
    endfunction

    function logic [63:0] span_years(logic [63:0] n, logic [63:0] a, logic [63:0] s,
                                     logic [63:0] sn);
        logic [127:0] t;
        t = ({64'd0, n * sn} << 28) + {64'd0, a * (s - sn)};
        return 64'(t >> 38);
    endfunction

    function void advance_group(logic [63:0] m, logic [63:0] n, logic [63:0] a);
        logic [63:0] am;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] sn;
        am = a * m;
        num = 0;
        sn = 0;
        if (am >= (64'd1 << 56))
            clipped = 1;
        else
            num = ((64'd1 << 56) - am) >> 28;
        den = ((64'd1 << 56) + ((n << 28) - a) * m) >> 28;
        if (num != 0)
            sn = surv * num / den;
        add_years(span_years(n, a, surv, sn));
        surv = sn;
    endfunction

    function void closed_request(logic [63:0] m, bit inf);
        int unsigned g;
        g = layout_abridged ? grp_idx : 2;
        if (grp_idx == 0)
            rate0 = inf ? 0 : m;
        if (g == 2)
        begin
            if (inf || m >= 64'd107374183)
            begin
                add_years(span_years(5, 64'd5 << 27, surv, 0));
                surv = 0;
                clipped = 1;
                stopped = 1;
                if (inf)
                    set_status(lea_pkg::STAT_SATURATED);
            end
            else
                advance_group(m, 5, 64'd5 << 27);
        end
        else if (inf)
        begin
            set_status(lea_pkg::STAT_SATURATED);
            stopped = 1;
        end
        else
            advance_group(m, g == 0 ? 1 : 4, sep_factor(g, g == 0 ? m : rate0));
        if (grp_idx < 2)
            grp_idx++;
    endfunction

    function void note_request(lea_pkg::item_t it);
        logic [63:0] m;
        lea_pkg::result_t r;
        m = {32'd0, it.rate};
        if (!stopped)
        begin
            if (it.rate_missing)
            begin
                set_status(lea_pkg::STAT_MISSING);
                stopped = 1;
            end
            else if (!it.rate_infinite && it.rate[31])
            begin
                set_status(lea_pkg::STAT_NEGATIVE);
                stopped = 1;
            end
            else if (it.open_group)
            begin
                if (it.rate_infinite)
                    set_status(lea_pkg::STAT_SATURATED);
                else if (m == 0)
                    add_years(64'h1_0000_0000);
                else
                    add_years((surv << 18) / m);
            end
            else
                closed_request(m, it.rate_infinite);
        end
        if (it.open_group)
        begin
            r.life_expectancy = (status == lea_pkg::STAT_MISSING ||
                                 status == lea_pkg::STAT_NEGATIVE) ? 32'd0 : years[31:0];
            r.row_status = status;
            r.probability_clipped = clipped;
            pending.push_back(r);
            clear_row();
        end
    endfunction

    function void check_result(lea_pkg::result_t got);
        lea_pkg::result_t exp_r;
        if (pending.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected result %h", got);
            return;
        end
        exp_r = pending.pop_front();
        if (got.life_expectancy !== exp_r.life_expectancy ||
            got.row_status !== exp_r.row_status ||
            got.probability_clipped !== exp_r.probability_clipped)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch: expected le=%h st=%0d clip=%0d, got le=%h st=%0d clip=%0d",
                         exp_r.life_expectancy, exp_r.row_status, exp_r.probability_clipped,
                         got.life_expectancy, got.row_status, got.probability_clipped);
        end
    endfunction
endclass

module tb;
    import lea_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    item_t       item;
    logic        result_valid;
    logic        result_ready;
    result_t     result;
    logic        cfg_write;
    logic        cfg_index;
    logic [1:0]  cfg_data;

    life_scoreboard rows;
    bit          sending_done;
    bit          hold_result;
    int unsigned sent_count;

    life_expectancy_ax_accumulator u_top (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #60_000_000;
        $display("Verification failed");
        $finish;
    end

    task automatic send_request(logic signed [31:0] r, bit miss, bit inf, bit open_g);
        int unsigned gap;
        gap = $urandom_range(0, 16);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= '{rate: r, rate_missing: miss, rate_infinite: inf, open_group: open_g};
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        rows.note_request('{rate: r, rate_missing: miss, rate_infinite: inf,
                            open_group: open_g});
        sent_count++;
    endtask

    task automatic write_reg(logic idx, logic [1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_AGE_LAYOUT)
            rows.layout_abridged = val[0];
        else
            rows.method = val;
        @(posedge clk);
    endtask

    task automatic drain();
        int unsigned guard;
        guard = 0;
        item_valid <= 1'b0;
        while (rows.pending.size() != 0 && guard < 100_000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (400) @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_rate();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(0, 1000);
            2: return $urandom_range(107374180, 107374190);
            3: return $urandom_range(28_000_000, 107_000_000);
            default: return $urandom_range(100_000, 8_000_000);
        endcase
    endfunction

    task automatic send_row(int unsigned len);
        int unsigned k;
        bit miss;
        bit inf;
        logic signed [31:0] r;
        for (k = 0; k < len; k++)
        begin
            r = pick_rate();
            miss = ($urandom_range(0, 60) == 0);
            inf = ($urandom_range(0, 60) == 0);
            if ($urandom_range(0, 40) == 0)
                r = -r;
            send_request(r, miss, inf, k == len - 1);
        end
    endtask

    initial
    begin
        rows = new();
        rst_n = 0;
        item_valid = 0;
        item = '0;
        result_ready = 0;
        cfg_write = 0;
        cfg_index = CFG_AGE_LAYOUT;
        cfg_data = 0;
        sending_done = 0;
        hold_result = 0;
        sent_count = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(32'sd1_000_000, 0, 0, 0);
        send_request(32'sd300_000, 0, 0, 0);
        send_request(32'sd500_000, 0, 0, 0);
        send_request(32'sd10_000_000, 0, 0, 1);
        send_request(32'sd107374183, 0, 0, 0);
        send_request(32'sd5, 0, 0, 0);
        send_request(32'sd0, 0, 0, 1);
        send_request(32'sd2147483647, 0, 0, 0);
        send_request(32'sd0, 0, 0, 1);
        send_request(-32'sd2147483648, 0, 0, 0);
        send_request(32'sd1000, 0, 0, 1);
        send_request(32'sd1000, 1, 0, 0);
        send_request(32'sd1000, 0, 1, 1);
        send_request(32'sd1000, 0, 1, 0);
        send_request(-32'sd1, 0, 0, 1);
        send_request(32'sd1, 0, 0, 1);
        drain();
        write_reg(CFG_A0_METHOD, METHOD_CD_FEMALE);
        send_request(32'sd40_000_000, 0, 0, 0);
        send_request(32'sd2_000_000, 0, 0, 0);
        send_request(32'sd20_000_000, 0, 0, 1);
        drain();
        write_reg(CFG_A0_METHOD, METHOD_CD_MALE);
        send_request(32'sd10_000_000, 0, 0, 0);
        send_request(32'sd2_000_000, 0, 0, 0);
        send_request(32'sd20_000_000, 0, 0, 1);
        drain();
        write_reg(CFG_A0_METHOD, 2'd3);
        write_reg(CFG_AGE_LAYOUT, 2'd0);
        send_request(32'sd1_000_000, 0, 0, 0);
        send_request(32'sd20_000_000, 0, 0, 1);

        hold_result <= 1'b1;
        send_row(2);
        send_row(2);
        send_row(2);
        hold_result <= 1'b0;

        while (sent_count < 1950)
        begin
            drain();
            write_reg(CFG_AGE_LAYOUT, 2'($urandom_range(0, 1)));
            write_reg(CFG_A0_METHOD, 2'($urandom_range(0, 3)));
            repeat (20)
                send_row($urandom_range(1, 8));
        end
        drain();
        sending_done = 1;
    end

    initial
    begin
        int unsigned wait_n;
        @(posedge rst_n);
        forever
        begin
            if (hold_result)
            begin
                result_ready <= 1'b0;
                repeat (600) @(posedge clk);
            end
            wait_n = $urandom_range(0, 16);
            if ($urandom_range(0, 3) == 0)
                wait_n = 0;
            if (wait_n != 0)
            begin
                result_ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
            rows.check_result(result);
        end
    end

    initial
    begin
        wait (sending_done);
        if (rows.errors == 0 && rows.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
